>>> sv/fua_pkg.sv
// Shared types, widths and codes for the flow-updating averaging engine.
package fua_pkg;

    localparam int ID_W       = 16;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 40;
    localparam int CMD_W      = 3;
    localparam int DEF_MAX_NB = 32;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEADER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ENTRY  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TERM   = 3'd5;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EST    = 2'd1;
    localparam logic [1:0] KIND_FLOW   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CFG_OWN_ID = 1'b0;
    localparam logic CFG_INPUT  = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [ID_W-1:0]         node_id;
        logic signed [VAL_W-1:0] value;
        logic                    last_entry;
    } t_item;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic [ID_W-1:0]         result_id;
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              status;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [VAL_W-1:0] flow;
        logic signed [VAL_W-1:0] est;
    } t_entry;

endpackage

>>> sv/fua_div.sv
// Signed divider, one quotient bit per cycle, truncating toward zero.
module fua_div import fua_pkg::*; #(
    parameter int NW = ACC_W,
    parameter int DW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quo
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [NW-1:0]    r_q;
    logic             r_neg;
    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW:0]      w_shift;
    logic             w_ge;

    assign w_shift = {r_rem, r_q[NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_den <= i_den;
                r_rem <= '0;
                r_neg <= i_num[NW-1];
                r_q   <= i_num[NW-1] ? (~i_num + 1'b1) : i_num;
            end else if (r_run) begin
                r_rem <= w_ge ? DW'(w_shift - {1'b0, r_den}) : DW'(w_shift);
                r_q   <= {r_q[NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

>>> sv/flow_updating_average_engine_top.sv
// Flow-updating averaging node: neighbor table, sequencer and shared divider.
// An item is taken when start is high and busy is low; busy holds until all results are out.
// Table edits walk the table one entry at a time through one registered memory read port.
// A tick sums the table, runs the divider, reports the estimate, then one flow result per entry.
// Results appear as one-cycle strobes; the receiver cannot stall them.
// Synchronous active-low reset empties the table and clears estimate and message state.
module flow_updating_average_engine_top import fua_pkg::*; #(
    parameter int MAX_NEIGHBORS = DEF_MAX_NB
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [VAL_W-1:0] i_cfg_data,
    output logic             o_result_valid,
    output t_result          o_result
);
    localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND_A = 4'd1;
    localparam logic [3:0] S_FIND_B = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_SH_A  = 4'd4;
    localparam logic [3:0] S_SH_B  = 4'd5;
    localparam logic [3:0] S_ENT_A = 4'd6;
    localparam logic [3:0] S_ENT_B = 4'd7;
    localparam logic [3:0] S_SUM_A = 4'd8;
    localparam logic [3:0] S_SUM_B = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_UPD_A = 4'd11;
    localparam logic [3:0] S_UPD_B = 4'd12;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    t_entry r_mem [MAX_NEIGHBORS];

    logic [3:0]              r_state;
    t_item                   r_in;
    logic [ID_W-1:0]         r_own_id;
    logic signed [VAL_W-1:0] r_input;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_ptr;
    logic [AW-1:0]           r_fidx;
    logic                    r_found;
    t_entry                  r_hit;
    t_entry                  r_rd;
    logic signed [VAL_W-1:0] r_est;
    logic [AW-1:0]           r_slot;
    logic                    r_open;
    logic signed [ACC_W-1:0] r_acc_f;
    logic signed [ACC_W-1:0] r_acc_e;
    logic                    r_out_vld;
    t_result                 r_out;

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    t_entry                  w_wdata;
    logic                    w_div_start;
    logic signed [ACC_W-1:0] w_num;
    logic                    w_div_done;
    logic signed [ACC_W-1:0] w_quo;
    logic signed [VAL_W+1:0] w_newflow;
    logic signed [VAL_W-1:0] w_newflow_sat;
    logic signed [VAL_W-1:0] w_negval;
    logic signed [VAL_W-1:0] w_quo_sat;

    function automatic t_result status_word(input logic [ID_W-1:0] id, input logic [1:0] st);
        t_result res;
        res.result_kind  = KIND_STATUS;
        res.result_id    = id;
        res.result_value = '0;
        res.status       = st;
        res.last         = 1'b1;
        return res;
    endfunction

    // The flow update stays within two extra bits, so one clamp covers it.
    assign w_newflow = (VAL_W+2)'(r_rd.flow) + (VAL_W+2)'(r_est) - (VAL_W+2)'(r_rd.est);
    assign w_newflow_sat = (w_newflow > (VAL_W+2)'(SAT_HI)) ? VAL_W'(SAT_HI) :
                           (w_newflow < (VAL_W+2)'(SAT_LO)) ? VAL_W'(SAT_LO) :
                           VAL_W'(w_newflow);
    assign w_negval = (r_in.value == VAL_W'(SAT_LO)) ? VAL_W'(SAT_HI) : -r_in.value;
    assign w_quo_sat = (w_quo > SAT_HI) ? VAL_W'(SAT_HI) :
                       (w_quo < SAT_LO) ? VAL_W'(SAT_LO) : VAL_W'(w_quo);
    assign w_num = ACC_W'(r_input) - r_acc_f + r_acc_e;
    assign w_div_start = (r_state == S_SUM_A) && (r_ptr >= r_count);

    fua_div #(.NW(ACC_W), .DW(CW + 1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   ((CW + 1)'(r_count) + 1'b1),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr[AW-1:0];
        w_wdata = r_rd;
        unique case (r_state)
            S_EXEC: begin
                if (r_in.command == CMD_UP && !r_found && r_count < CW'(MAX_NEIGHBORS)) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[AW-1:0];
                    w_wdata = '{id: r_in.node_id, flow: '0, est: '0};
                end else if (r_in.command == CMD_HEADER) begin
                    if (r_found) begin
                        w_we    = 1'b1;
                        w_waddr = r_fidx;
                        w_wdata = '{id: r_hit.id, flow: r_hit.flow, est: r_in.value};
                    end else if (r_count < CW'(MAX_NEIGHBORS)) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        w_wdata = '{id: r_in.node_id, flow: '0, est: r_in.value};
                    end
                end
            end
            S_SH_B: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_ptr - 1'b1);
            end
            S_ENT_B: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = '{id: r_rd.id, flow: w_negval, est: r_rd.est};
            end
            S_UPD_B: begin
                w_we    = 1'b1;
                w_wdata = '{id: r_rd.id, flow: w_newflow_sat, est: r_est};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_own_id  <= '0;
            r_input   <= '0;
            r_count   <= '0;
            r_ptr     <= '0;
            r_est     <= '0;
            r_slot    <= '0;
            r_open    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OWN_ID) begin
                    r_own_id <= i_cfg_data[ID_W-1:0];
                end else begin
                    r_input <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in  <= i_item;
                        r_ptr <= '0;
                        unique case (i_item.command) inside
                            CMD_TICK: begin
                                r_open  <= 1'b0;
                                r_acc_f <= '0;
                                r_acc_e <= '0;
                                r_state <= S_SUM_A;
                            end
                            CMD_UP, CMD_DOWN, CMD_HEADER: begin
                                r_state <= S_FIND_A;
                            end
                            CMD_ENTRY: begin
                                if (r_open && i_item.node_id == r_own_id
                                        && CW'(r_slot) < r_count) begin
                                    r_ptr   <= CW'(r_slot);
                                    r_state <= S_ENT_A;
                                end else begin
                                    if (i_item.last_entry) begin
                                        r_open <= 1'b0;
                                    end
                                    r_out_vld <= 1'b1;
                                    r_out     <= status_word(i_item.node_id, ST_OK);
                                end
                            end
                            CMD_TERM: begin
                                r_count   <= '0;
                                r_est     <= '0;
                                r_slot    <= '0;
                                r_open    <= 1'b0;
                                r_out_vld <= 1'b1;
                                r_out     <= status_word(i_item.node_id, ST_OK);
                            end
                            default: begin
                                r_out_vld <= 1'b1;
                                r_out     <= status_word(i_item.node_id, ST_NOTFOUND);
                            end
                        endcase
                    end
                end
                S_FIND_A: begin
                    if (r_ptr >= r_count) begin
                        r_found <= 1'b0;
                        r_state <= S_EXEC;
                    end else begin
                        r_state <= S_FIND_B;
                    end
                end
                S_FIND_B: begin
                    if (r_rd.id == r_in.node_id) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_ptr[AW-1:0];
                        r_hit   <= r_rd;
                        r_state <= S_EXEC;
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_FIND_A;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_out   <= status_word(r_in.node_id, ST_OK);
                    r_out_vld <= 1'b1;
                    case (r_in.command)
                        CMD_UP: begin
                            if (r_found) begin
                                r_out <= status_word(r_in.node_id, ST_DUP);
                            end else if (r_count >= CW'(MAX_NEIGHBORS)) begin
                                r_out <= status_word(r_in.node_id, ST_FULL);
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        CMD_DOWN: begin
                            if (!r_found) begin
                                r_out <= status_word(r_in.node_id, ST_NOTFOUND);
                            end else begin
                                // Removal shifts later entries up; the open message follows.
                                r_out_vld <= 1'b0;
                                if (r_open) begin
                                    if (r_slot == r_fidx) begin
                                        r_open <= 1'b0;
                                    end else if (r_slot > r_fidx) begin
                                        r_slot <= r_slot - 1'b1;
                                    end
                                end
                                r_ptr   <= CW'(r_fidx) + 1'b1;
                                r_state <= S_SH_A;
                            end
                        end
                        default: begin
                            if (r_found) begin
                                r_slot <= r_fidx;
                                r_open <= !r_in.last_entry;
                            end else if (r_count < CW'(MAX_NEIGHBORS)) begin
                                r_slot  <= r_count[AW-1:0];
                                r_open  <= !r_in.last_entry;
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_open <= 1'b0;
                                r_out  <= status_word(r_in.node_id, ST_FULL);
                            end
                        end
                    endcase
                end
                S_SH_A: begin
                    if (r_ptr >= r_count) begin
                        r_count   <= r_count - 1'b1;
                        r_out_vld <= 1'b1;
                        r_out     <= status_word(r_in.node_id, ST_OK);
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_SH_B;
                    end
                end
                S_SH_B: begin
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= S_SH_A;
                end
                S_ENT_A: begin
                    r_state <= S_ENT_B;
                end
                S_ENT_B: begin
                    r_open    <= 1'b0;
                    r_out_vld <= 1'b1;
                    r_out     <= status_word(r_in.node_id, ST_OK);
                    r_state   <= S_IDLE;
                end
                S_SUM_A: begin
                    r_state <= (r_ptr >= r_count) ? S_DIV : S_SUM_B;
                end
                S_SUM_B: begin
                    r_acc_f <= r_acc_f + ACC_W'(r_rd.flow);
                    r_acc_e <= r_acc_e + ACC_W'(r_rd.est);
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= S_SUM_A;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_est     <= w_quo_sat;
                        r_ptr     <= '0;
                        r_out_vld <= 1'b1;
                        r_out     <= '{result_kind: KIND_EST, result_id: r_own_id,
                                       result_value: w_quo_sat, status: ST_OK,
                                       last: (r_count == '0)};
                        r_state   <= (r_count == '0) ? S_IDLE : S_UPD_A;
                    end
                end
                S_UPD_A: begin
                    r_state <= S_UPD_B;
                end
                S_UPD_B: begin
                    r_out_vld <= 1'b1;
                    r_out     <= '{result_kind: KIND_FLOW, result_id: r_rd.id,
                                   result_value: w_newflow_sat, status: ST_OK,
                                   last: (r_ptr + 1'b1 == r_count)};
                    r_ptr     <= r_ptr + 1'b1;
                    r_state   <= (r_ptr + 1'b1 == r_count) ? S_IDLE : S_UPD_A;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

endmodule

>>> bench/tb_flow_updating_average_engine_top.sv
// Self-checking testbench for the flow-updating averaging engine top level.
`timescale 1ns / 100ps

module tb_flow_updating_average_engine_top;
    import fua_pkg::*;

    localparam int NB = 32;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 410;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [VAL_W-1:0] i_cfg_data;
    logic             o_result_valid;
    t_result          o_result;

    flow_updating_average_engine_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Shadow copy of the node state.
    logic [ID_W-1:0] nb_id [NB];
    longint          nb_flow [NB];
    longint          nb_est [NB];
    int              nb_count;
    longint          cur_est;
    int              msg_slot;
    bit              msg_open;
    logic [ID_W-1:0] own_id_r;
    longint          input_r;

    t_result pending_results[$];
    int      errors;
    int      cycles;
    bit      gaps_on;
    logic [ID_W-1:0] id_pool [40];

    typedef struct {
        t_item      it;
        bit         typed;
        logic [1:0] st;
    } t_row;

    t_row dir_rows[$];

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic t_result make_result(logic [1:0] kind, logic [ID_W-1:0] id,
                                            longint val, logic [1:0] st, bit last);
        t_result r;
        r.result_kind  = kind;
        r.result_id    = id;
        r.result_value = val[VAL_W-1:0];
        r.status       = st;
        r.last         = last;
        return r;
    endfunction

    function automatic int find_neighbor(logic [ID_W-1:0] id);
        for (int i = 0; i < nb_count; i++)
            if (nb_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int add_neighbor(logic [ID_W-1:0] id);
        if (nb_count >= NB) return -1;
        nb_id[nb_count] = id;
        nb_flow[nb_count] = 0;
        nb_est[nb_count] = 0;
        nb_count++;
        return nb_count - 1;
    endfunction

    // Updates the shadow state for one accepted word and queues its results.
    // When keep is clear, only the state moves; the caller queues its own result.
    function automatic void predict_node(t_item it, bit keep);
        longint     flows, ests, num, d, val;
        int         s;
        logic [1:0] st;
        flows = 0;
        ests = 0;
        st = ST_OK;
        val = longint'(it.value);
        if (it.command == CMD_TICK) begin
            msg_open = 0;
            for (int i = 0; i < nb_count; i++) begin
                flows += nb_flow[i];
                ests += nb_est[i];
            end
            num = input_r - flows + ests;
            cur_est = sat32(num / longint'(nb_count + 1));
            if (keep) pending_results.push_back(make_result(KIND_EST, own_id_r, cur_est,
                                                             ST_OK, nb_count == 0));
            for (int i = 0; i < nb_count; i++) begin
                d = cur_est - nb_est[i];
                nb_flow[i] = sat32(nb_flow[i] + d);
                nb_est[i] = cur_est;
                if (keep) pending_results.push_back(make_result(KIND_FLOW, nb_id[i],
                                                                 nb_flow[i], ST_OK,
                                                                 i + 1 == nb_count));
            end
            return;
        end
        case (it.command)
            CMD_UP: begin
                if (find_neighbor(it.node_id) >= 0) st = ST_DUP;
                else if (add_neighbor(it.node_id) < 0) st = ST_FULL;
            end
            CMD_DOWN: begin
                s = find_neighbor(it.node_id);
                if (s < 0) begin
                    st = ST_NOTFOUND;
                end else begin
                    if (msg_open) begin
                        if (msg_slot == s) msg_open = 0;
                        else if (msg_slot > s) msg_slot--;
                    end
                    for (int i = s; i + 1 < nb_count; i++) begin
                        nb_id[i] = nb_id[i+1];
                        nb_flow[i] = nb_flow[i+1];
                        nb_est[i] = nb_est[i+1];
                    end
                    nb_count--;
                end
            end
            CMD_HEADER: begin
                s = find_neighbor(it.node_id);
                if (s < 0) s = add_neighbor(it.node_id);
                if (s < 0) begin
                    st = ST_FULL;
                    msg_open = 0;
                end else begin
                    nb_est[s] = val;
                    msg_slot = s;
                    msg_open = !it.last_entry;
                end
            end
            CMD_ENTRY: begin
                if (msg_open) begin
                    if (it.node_id == own_id_r && msg_slot < nb_count) begin
                        nb_flow[msg_slot] = sat32(-val);
                        msg_open = 0;
                    end
                    if (it.last_entry) msg_open = 0;
                end
            end
            CMD_TERM: begin
                nb_count = 0;
                cur_est = 0;
                msg_slot = 0;
                msg_open = 0;
            end
            default: st = ST_NOTFOUND;
        endcase
        if (keep) pending_results.push_back(make_result(KIND_STATUS, it.node_id, 0, st, 1));
    endfunction

    // Result checker: every strobed word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word %h", $time, o_result);
            end else begin
                e = pending_results.pop_front();
                if (o_result.result_kind !== e.result_kind || o_result.result_id !== e.result_id
                    || o_result.result_value !== e.result_value || o_result.status !== e.status
                    || o_result.last !== e.last) begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d id=%h val=%h st=%0d last=%0b",
                             $time, e.result_kind, e.result_id, e.result_value, e.status,
                             e.last);
                    $display("%0t:          actual kind=%0d id=%h val=%h st=%0d last=%0b",
                             $time, o_result.result_kind, o_result.result_id,
                             o_result.result_value, o_result.status, o_result.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("flow_updating_average_engine_top regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_item it, bit typed, logic [1:0] st);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item = it;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_node(it, !typed);
        if (typed)
            pending_results.push_back(make_result(KIND_STATUS, it.node_id, 0, st, 1));
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // Register writes happen only with the engine drained.
    task automatic write_reg(logic idx, logic [VAL_W-1:0] data);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_OWN_ID) own_id_r = data[ID_W-1:0];
        else input_r = longint'(signed'(data));
    endtask

    function automatic t_item mk_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                      logic [VAL_W-1:0] v, logic last);
        t_item it;
        it.command = cmd;
        it.node_id = id;
        it.value = v;
        it.last_entry = last;
        return it;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                    logic [VAL_W-1:0] v, logic last, bit typed,
                                    logic [1:0] st);
        t_row r;
        r.it = mk_item(cmd, id, v, last);
        r.typed = typed;
        r.st = st;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return {{16{1'b0}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pool_id();
        return id_pool[$urandom_range(0, 39)];
    endfunction

    initial begin
        int sent;
        int n;
        int r;
        logic [VAL_W-1:0] own_set [4];
        logic [VAL_W-1:0] in_set [4];
        errors = 0;
        cycles = 0;
        gaps_on = 1;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_OWN_ID;
        i_cfg_data = '0;
        nb_count = 0;
        cur_est = 0;
        msg_slot = 0;
        msg_open = 0;
        own_id_r = '0;
        input_r = 0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_OWN_ID, 32'h0000_FFFF);
        write_reg(CFG_INPUT, 32'h7FFF_FFFF);

        add_row(CMD_TICK,   16'h0000, 32'h0, 1'b0, 0, ST_OK);
        add_row(CMD_DOWN,   16'h0005, 32'h0, 1'b0, 1, ST_NOTFOUND);
        add_row(CMD_UP,     16'h0000, 32'h0, 1'b0, 1, ST_OK);
        add_row(CMD_UP,     16'h0000, 32'h0, 1'b0, 1, ST_DUP);
        add_row(CMD_UP,     16'hFFFF, 32'h0, 1'b1, 1, ST_OK);
        add_row(CMD_HEADER, 16'h0000, 32'h8000_0000, 1'b0, 1, ST_OK);
        add_row(CMD_ENTRY,  16'h1111, 32'h5, 1'b0, 1, ST_OK);
        // Negating the most negative flow saturates to the top of the range.
        add_row(CMD_ENTRY,  16'hFFFF, 32'h8000_0000, 1'b0, 1, ST_OK);
        add_row(CMD_ENTRY,  16'hFFFF, 32'h7FFF_FFFF, 1'b1, 1, ST_OK);
        add_row(CMD_TICK,   16'h0000, 32'h0, 1'b0, 0, ST_OK);
        add_row(CMD_HEADER, 16'h00AA, 32'h7FFF_FFFF, 1'b1, 1, ST_OK);
        add_row(3'd6,       16'h1234, 32'hFFFF_FFFF, 1'b1, 1, ST_NOTFOUND);
        add_row(3'd7,       16'hFFFF, 32'h0, 1'b0, 1, ST_NOTFOUND);
        add_row(CMD_HEADER, 16'h0000, 32'h0001_0000, 1'b0, 1, ST_OK);
        // Removing the sender closes its message, so the entry is dropped.
        add_row(CMD_DOWN,   16'h0000, 32'h0, 1'b0, 1, ST_OK);
        add_row(CMD_ENTRY,  16'hFFFF, 32'h1234_5678, 1'b1, 1, ST_OK);
        add_row(CMD_TICK,   16'h0000, 32'h0, 1'b0, 0, ST_OK);
        add_row(CMD_TERM,   16'hABCD, 32'h0, 1'b0, 1, ST_OK);
        add_row(CMD_TICK,   16'h0000, 32'h0, 1'b0, 0, ST_OK);

        @(negedge i_clk);
        foreach (dir_rows[k]) send_word(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].st);

        own_set = '{32'h0, 32'hFFFF, 32'h0, 32'h0};
        in_set = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0};
        own_set[2] = $urandom_range(0, 65535);
        own_set[3] = $urandom_range(0, 65535);
        in_set[3] = $urandom;

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_OWN_ID, own_set[ph]);
            write_reg(CFG_INPUT, in_set[ph]);
            gaps_on = (ph != 1);
            foreach (id_pool[k]) id_pool[k] = ID_W'($urandom_range(0, 65535));
            @(negedge i_clk);
            while (sent < (ph + 1) * RANDOM_ITEMS / 4) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    send_word(mk_item(CMD_TICK, ID_W'($urandom), $urandom, 1'($urandom)),
                              0, ST_OK);
                end else if (r < 40) begin
                    send_word(mk_item(CMD_UP, pool_id(), $urandom, 1'($urandom)), 0, ST_OK);
                end else if (r < 48) begin
                    send_word(mk_item(CMD_DOWN, pool_id(), $urandom, 1'($urandom)), 0, ST_OK);
                end else if (r < 80) begin
                    // A message: header, then a few entries, some naming this node.
                    send_word(mk_item(CMD_HEADER, pool_id(), rand_value(),
                                      $urandom_range(0, 5) == 0), 0, ST_OK);
                    n = $urandom_range(1, 4);
                    for (int e = 0; e < n; e++) begin
                        send_word(mk_item(CMD_ENTRY,
                                          $urandom_range(0, 2) == 0 ? own_id_r : pool_id(),
                                          rand_value(), e == n - 1 ? 1'($urandom) : 1'b0),
                                  0, ST_OK);
                        sent++;
                    end
                end else if (r < 88) begin
                    send_word(mk_item(CMD_ENTRY, $urandom_range(0, 1) ? own_id_r : pool_id(),
                                      rand_value(), 1'($urandom)), 0, ST_OK);
                end else if (r < 90) begin
                    send_word(mk_item(CMD_TERM, ID_W'($urandom), $urandom, 1'($urandom)),
                              0, ST_OK);
                end else if (r < 92) begin
                    send_word(mk_item(3'($urandom_range(6, 7)), ID_W'($urandom), $urandom,
                                      1'($urandom)),
                              0, ST_OK);
                end else begin
                    send_word(mk_item(CMD_UP, pool_id(), $urandom, 1'($urandom)), 0, ST_OK);
                end
                sent++;
            end
        end

        drain();
        if (errors == 0)
            $display("flow_updating_average_engine_top regression: pass");
        else
            $display("flow_updating_average_engine_top regression: fail");
        $finish;
    end

endmodule
